// ===== rtl/gpw_pkg.sv =====
// Shared constants and types for the glide path waypoint generator.
package gpw_pkg;

  localparam int COORD_W_DEF    = 10;
  localparam int MAX_STEPS_DEF  = 64;
  localparam int SEED_CAP       = 1024;
  localparam int SQRT_TOL       = 3;
  localparam int ROUND_LIMIT    = 64;
  localparam int LEN_W          = 8;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 3;
  localparam logic [LEN_W-1:0] STEP_LEN_RESET = 8'd15;

  typedef enum logic [3:0] {
    F_IDLE, F_SQ, F_SEED, F_CHECK, F_MUL, F_DIVGO, F_DIV, F_STEPDIV, F_STEPS, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_NEXT, B_DIVX, B_DIVY, B_LAST, B_EMIT
  } back_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/gpw_if.sv =====
// Request channel interfaces for input points and output waypoints.
interface gpw_in_if #(parameter int W = 10);
  logic         valid;
  logic         ready;
  logic [W-1:0] start_x;
  logic [W-1:0] start_y;
  logic [W-1:0] end_x;
  logic [W-1:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface gpw_out_if #(parameter int W = 10);
  logic         valid;
  logic         ready;
  logic [W-1:0] point_x;
  logic [W-1:0] point_y;
  logic         last;
  modport source (output valid, point_x, point_y, last, input ready);
  modport sink   (input valid, point_x, point_y, last, output ready);
endinterface

// ===== rtl/gpw_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module gpw_div import gpw_pkg::*; #(
  parameter int N = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] num,
  input  logic [N-1:0] den,
  output logic [N-1:0] quo,
  output div_stat_t    stat
);
  localparam int CW = $clog2(N + 1);

  logic [N:0]    rem_r;
  logic [N-1:0]  quo_r;
  logic [N-1:0]  den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [N:0]    trial;

  assign trial = {rem_r[N-1:0], quo_r[N-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        quo_r <= {quo_r[N-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[N-2:0], 1'b0};
      end
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

// ===== rtl/gpw_front.sv =====
// Front end: accept a request, find the glide length by Newton root, set the step count.
module gpw_front import gpw_pkg::*; #(
  parameter int W  = COORD_W_DEF,
  parameter int MS = MAX_STEPS_DEF,
  parameter int EW = 4 * W + $clog2(MS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  gpw_in_if.sink           in_ch,
  input  logic [LEN_W-1:0] step_len,
  input  q_stat_t          q_stat,
  output logic             q_push,
  output logic [EW-1:0]    q_wdata
);
  localparam int GW  = 2 * W + 2;
  localparam int PW  = 2 * GW;
  localparam int SW  = $clog2(MS + 1);
  localparam int RW  = $clog2(ROUND_LIMIT + 1);
  localparam int MCW = $clog2(GW + 1);

  front_state_t   state_r, state_nxt;
  logic [W-1:0]   sx_r, sy_r, ex_r, ey_r;
  logic [GW-1:0]  sq_r, g_r, prev_r;
  logic [RW-1:0]  rounds_r;
  logic [PW-1:0]  mcand_r, prod_r;
  logic [GW-1:0]  mplier_r;
  logic [MCW-1:0] mcnt_r;
  logic           neg_r;
  logic [SW-1:0]  steps_r;

  logic [W-1:0]   adx, ady;
  logic [2*W-1:0] sqx, sqy;
  logic [GW-1:0]  half, seed, diff;
  logic           div_start;
  logic [PW-1:0]  div_num, div_den, div_quo;
  div_stat_t      div_stat;
  logic [PW:0]    gn;
  logic [PW:0]    qe;
  logic [LEN_W-1:0] len;

  assign adx  = (ex_r >= sx_r) ? ex_r - sx_r : sx_r - ex_r;
  assign ady  = (ey_r >= sy_r) ? ey_r - sy_r : sy_r - ey_r;
  assign sqx  = adx * adx;
  assign sqy  = ady * ady;
  assign half = sq_r >> 1;
  assign seed = (half > GW'(SEED_CAP)) ? GW'(SEED_CAP) : half;
  assign diff = (g_r >= prev_r) ? g_r - prev_r : prev_r - g_r;
  assign len  = (step_len == '0) ? LEN_W'(1) : step_len;
  assign gn   = neg_r ? {1'b0, PW'(g_r)} + {1'b0, div_quo}
                      : {1'b0, PW'(g_r)} - {1'b0, div_quo};
  assign qe   = {1'b0, div_quo} + (PW + 1)'(div_quo[0]);

  gpw_div #(.N(PW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    div_num     = prod_r >= PW'(sq_r) ? prod_r - PW'(sq_r) : PW'(sq_r) - prod_r;
    div_den     = PW'({g_r, 1'b0});
    q_push      = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_nxt = F_SQ;
      end
      F_SQ:    state_nxt = F_SEED;
      F_SEED:  state_nxt = (seed == '0) ? F_STEPDIV : F_CHECK;
      F_CHECK: begin
        if (diff <= GW'(SQRT_TOL) || rounds_r == RW'(ROUND_LIMIT)) state_nxt = F_STEPDIV;
        else state_nxt = F_MUL;
      end
      F_MUL:   if (mcnt_r == MCW'(1)) state_nxt = F_DIVGO;
      F_DIVGO: begin
        div_start = 1'b1;
        state_nxt = F_DIV;
      end
      F_DIV:   if (div_stat.done) state_nxt = F_CHECK;
      F_STEPDIV: begin
        div_start = 1'b1;
        div_num   = PW'(g_r);
        div_den   = PW'(len);
        state_nxt = F_STEPS;
      end
      F_STEPS: if (div_stat.done) state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_stat.full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          sx_r <= in_ch.start_x;
          sy_r <= in_ch.start_y;
          ex_r <= in_ch.end_x;
          ey_r <= in_ch.end_y;
        end
      end
      F_SQ: sq_r <= GW'(sqx) + GW'(sqy);
      F_SEED: begin
        g_r      <= seed;
        prev_r   <= sq_r;
        rounds_r <= '0;
      end
      F_CHECK: begin
        prev_r   <= g_r;
        prod_r   <= '0;
        mcand_r  <= PW'(g_r);
        mplier_r <= g_r;
        mcnt_r   <= MCW'(GW);
      end
      F_MUL: begin
        if (mplier_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        mcnt_r   <= mcnt_r - 1'b1;
      end
      F_DIVGO: neg_r <= prod_r < PW'(sq_r);
      F_DIV: begin
        if (div_stat.done) begin
          if (gn[PW] || gn == '0) g_r <= GW'(1);
          else                     g_r <= gn[GW-1:0];
          rounds_r <= rounds_r + 1'b1;
        end
      end
      F_STEPS: begin
        if (div_stat.done) begin
          if (qe >= (PW + 1)'(MS)) steps_r <= SW'(MS);
          else                      steps_r <= qe[SW-1:0];
        end
      end
      F_STEPDIV, F_PUSH: begin
      end
      default: begin
      end
    endcase
  end

  assign q_wdata = {sx_r, sy_r, ex_r, ey_r, steps_r};
endmodule

// ===== rtl/gpw_queue.sv =====
// Two-entry queue between the front and back ends.
module gpw_queue import gpw_pkg::*; #(
  parameter int EW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [EW-1:0] wdata,
  input  logic          pop,
  output logic [EW-1:0] rdata,
  output q_stat_t       stat
);
  localparam int PTW = $clog2(DEPTH);
  localparam int CTW = $clog2(DEPTH + 1);

  logic [EW-1:0]  mem_r [DEPTH];
  logic [PTW-1:0] wptr_r, rptr_r;
  logic [CTW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == PTW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (pop)  rptr_r <= (rptr_r == PTW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  assign rdata      = mem_r[rptr_r];
  assign stat.full  = cnt_r == CTW'(DEPTH);
  assign stat.empty = cnt_r == '0;
endmodule

// ===== rtl/gpw_back.sv =====
// Back end: step along the glide and emit each waypoint through the output register.
module gpw_back import gpw_pkg::*; #(
  parameter int W  = COORD_W_DEF,
  parameter int MS = MAX_STEPS_DEF,
  parameter int EW = 4 * W + $clog2(MS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  q_stat_t       q_stat,
  input  logic [EW-1:0] q_rdata,
  output logic          q_pop,
  gpw_out_if.source     out_ch
);
  localparam int SW = $clog2(MS + 1);
  localparam int BW = W + SW;

  back_state_t   state_r, state_nxt;
  logic [W-1:0]  sx_r, sy_r, ex_r, ey_r;
  logic [W-1:0]  adx_r, ady_r, qx_r;
  logic          negx_r, negy_r;
  logic [SW-1:0] steps_r, i_r;
  logic [BW-1:0] accx_r, accy_r;
  logic [W-1:0]  hx_r, hy_r;
  logic          hlast_r;
  logic          ovalid_r;
  logic [W-1:0]  px_r, py_r;
  logic          plast_r;

  logic [W-1:0]  qsx, qsy, qex, qey;
  logic [SW-1:0] qsteps;
  logic          div_start;
  logic [BW-1:0] div_num, div_quo;
  div_stat_t     div_stat;
  logic          slot_free;
  logic          load_out;

  assign {qsx, qsy, qex, qey, qsteps} = q_rdata;
  assign slot_free = !ovalid_r || out_ch.ready;

  gpw_div #(.N(BW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (BW'(steps_r)),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_num   = accx_r;
    load_out  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = B_NEXT;
        end
      end
      B_NEXT: begin
        if (i_r < steps_r) begin
          div_start = 1'b1;
          state_nxt = B_DIVX;
        end else begin
          state_nxt = B_LAST;
        end
      end
      B_DIVX: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_num   = accy_r;
          state_nxt = B_DIVY;
        end
      end
      B_DIVY: if (div_stat.done) state_nxt = B_EMIT;
      B_LAST: state_nxt = B_EMIT;
      B_EMIT: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = hlast_r ? B_IDLE : B_NEXT;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)          ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        sx_r    <= qsx;
        sy_r    <= qsy;
        ex_r    <= qex;
        ey_r    <= qey;
        steps_r <= qsteps;
        adx_r   <= (qex >= qsx) ? qex - qsx : qsx - qex;
        ady_r   <= (qey >= qsy) ? qey - qsy : qsy - qey;
        negx_r  <= qex < qsx;
        negy_r  <= qey < qsy;
        accx_r  <= BW'((qex >= qsx) ? qex - qsx : qsx - qex);
        accy_r  <= BW'((qey >= qsy) ? qey - qsy : qsy - qey);
        i_r     <= SW'(1);
      end
      B_DIVX: if (div_stat.done) qx_r <= div_quo[W-1:0];
      B_DIVY: begin
        if (div_stat.done) begin
          hx_r    <= negx_r ? sx_r - qx_r : sx_r + qx_r;
          hy_r    <= negy_r ? sy_r - div_quo[W-1:0] : sy_r + div_quo[W-1:0];
          hlast_r <= 1'b0;
        end
      end
      B_LAST: begin
        hx_r    <= ex_r;
        hy_r    <= ey_r;
        hlast_r <= 1'b1;
      end
      B_EMIT: begin
        if (slot_free) begin
          i_r    <= i_r + 1'b1;
          accx_r <= accx_r + BW'(adx_r);
          accy_r <= accy_r + BW'(ady_r);
        end
      end
      B_NEXT: begin
      end
      default: begin
      end
    endcase
    if (load_out) begin
      px_r    <= hx_r;
      py_r    <= hy_r;
      plast_r <= hlast_r;
    end
  end

  assign out_ch.valid   = ovalid_r;
  assign out_ch.point_x = px_r;
  assign out_ch.point_y = py_r;
  assign out_ch.last    = plast_r;
endmodule

// ===== rtl/glide_path_waypoint_generator.sv =====
// Top level of the glide path waypoint generator.
//   channel  | dir | handshake             | payload
//   in_ch    | in  | valid/ready           | start_x start_y end_x end_y
//   out_ch   | out | valid/ready           | point_x point_y last
//   cfg      | in  | psel/penable, pready  | step_length at byte addresses 0 to 3
// Front end: per Newton round a serial multiply, then a serial divide; 0 to ROUND_LIMIT rounds,
// then a serial divide for the step count.
// Back end: per waypoint a serial divide for x, then one for y, on its own divider.
// A two-entry queue lets the front end work on the next request while waypoints drain.
// Reset is synchronous; output stalls hold the back end, a full queue holds the front end.
module glide_path_waypoint_generator import gpw_pkg::*; #(
  parameter int COORD_W   = COORD_W_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  gpw_in_if.sink            in_ch,
  gpw_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);
  localparam int EW = 4 * COORD_W + $clog2(MAX_STEPS + 1);

  logic [LEN_W-1:0] step_len_r;
  logic             q_push, q_pop;
  logic [EW-1:0]    q_wdata, q_rdata;
  q_stat_t          q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_len_r <= STEP_LEN_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      step_len_r <= pwdata[LEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = !paddr[2] ? DATA_W'(step_len_r) : '0;

  gpw_front #(.W(COORD_W), .MS(MAX_STEPS), .EW(EW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .step_len (step_len_r),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  gpw_queue #(.EW(EW), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  gpw_back #(.W(COORD_W), .MS(MAX_STEPS), .EW(EW)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule

// ===== rtl/gpw_checker.sv =====
// Port-level assertions for the glide path waypoint generator, bound to the top level.
module gpw_checker import gpw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before request processed");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && !paddr[2] |=>
      (paddr[2] || prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0])))
    else $error("step length readback mismatch");
endmodule

bind glide_path_waypoint_generator gpw_checker u_gpw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
